// File: hdl/vbspd_pkg.sv
// Shared constants and types for the majority-vote bit slicer and preamble deframer.
package vbspd_pkg;

    // Field widths
    localparam int LAT_W    = 12;
    localparam int FLIPS_W  = 4;
    localparam int TALLY_W  = 16;
    localparam int ZRUN_W   = 4;

    // Stream payload widths; tdata is padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 3;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_ADDR_W-1:0] REG_MISS_THRESHOLD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FLIPS_NEEDED   = 1'd1;

    // Reset values of the registers
    localparam logic [LAT_W-1:0]   MISS_THRESHOLD_RST = 12'd200;
    localparam logic [FLIPS_W-1:0] FLIPS_NEEDED_RST   = 4'd4;

    // Framing limits
    localparam int MAX_PAYLOAD_BITS = 4096;
    localparam int PBITS_W          = $clog2(MAX_PAYLOAD_BITS + 1);
    localparam logic [PBITS_W-1:0] MAX_PBITS = PBITS_W'(MAX_PAYLOAD_BITS);
    localparam logic [ZRUN_W-1:0]  ZERO_BYTE_LEN = 4'd8;

    // Result flags carried on tuser, highest bit first
    typedef struct packed {
        logic length_overflow;
        logic sync_found;
        logic payload_valid;
    } t_flags;

endpackage

// File: hdl/vote_bit_slicer_preamble_deframer_top.sv
// Majority-vote bit slicer with preamble hunt and zero-byte message deframing.
//
// Takes one latency sample per clock. Each sample below miss_threshold counts as a hit,
// otherwise as a miss; the sample that carries tlast closes the bit interval, and the bit is
// 1 when misses are fewer than hits. Each closed interval gives one result, shown in the
// cycle after it through an output register; other samples give none. While hunting, the
// block waits for flips_needed alternations followed by two 1 bits (sync_found marks that
// interval); it then passes payload bits until a byte-aligned zero byte (tlast on that bit)
// or MAX_PAYLOAD_BITS bits (tlast plus length_overflow), and hunts again. Rate: one sample
// every cycle; the input stalls only while a held result is not taken by the sink.
module vote_bit_slicer_preamble_deframer_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration writes
    input  logic                                  i_cfg_we,
    input  logic [vbspd_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [vbspd_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // Sample stream
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [vbspd_pkg::S_TDATA_W-1:0]       i_s_tdata,  // [11:0] access_latency
    input  logic                                  i_s_tlast,  // interval_last
    // Result stream
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [vbspd_pkg::M_TDATA_W-1:0]       o_m_tdata,  // [0] decided_bit
    output logic                                  o_m_tlast,  // message_end
    output logic [vbspd_pkg::M_TUSER_W-1:0]       o_m_tuser   // [0] payload_valid,
                                                              // [1] sync_found,
                                                              // [2] length_overflow
);

    // Configuration registers
    logic [vbspd_pkg::LAT_W-1:0]    r_miss_threshold;
    logic [vbspd_pkg::FLIPS_W-1:0]  r_flips_needed;

    // Slicer and framing state
    logic [vbspd_pkg::TALLY_W-1:0]  r_hit_tally, n_hit_tally;
    logic [vbspd_pkg::TALLY_W-1:0]  r_miss_tally, n_miss_tally;
    logic                           r_previous_bit, n_previous_bit;
    logic [vbspd_pkg::FLIPS_W-1:0]  r_flips_left, n_flips_left;
    logic                           r_in_payload, n_in_payload;
    logic [vbspd_pkg::PBITS_W-1:0]  r_payload_bits, n_payload_bits;
    logic [vbspd_pkg::ZRUN_W-1:0]   r_zero_run, n_zero_run;

    // Output register
    logic                           r_out_valid;
    logic                           r_out_bit, n_out_bit;
    logic                           r_out_end, n_out_end;
    vbspd_pkg::t_flags              r_out_flags, n_out_flags;

    logic                           s_accept;
    logic [vbspd_pkg::LAT_W-1:0]    lat;
    logic                           is_hit;
    logic [vbspd_pkg::TALLY_W-1:0]  hit_sum, miss_sum;
    logic                           bit_val;
    logic [vbspd_pkg::PBITS_W-1:0]  pbits_inc;
    logic [vbspd_pkg::ZRUN_W-1:0]   zrun_upd;
    logic                           zero_byte_end;

    // Take a new sample whenever the output register is free or being emptied
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Hold configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_threshold <= vbspd_pkg::MISS_THRESHOLD_RST;
            r_flips_needed   <= vbspd_pkg::FLIPS_NEEDED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                vbspd_pkg::REG_MISS_THRESHOLD: begin
                    r_miss_threshold <= i_cfg_wdata[vbspd_pkg::LAT_W-1:0];
                end
                vbspd_pkg::REG_FLIPS_NEEDED: begin
                    r_flips_needed <= i_cfg_wdata[vbspd_pkg::FLIPS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Classify the sample and advance the saturating tallies
    assign lat      = i_s_tdata[vbspd_pkg::LAT_W-1:0];
    assign is_hit   = lat < r_miss_threshold;
    assign hit_sum  = (is_hit && r_hit_tally != '1) ? r_hit_tally + 1'b1 : r_hit_tally;
    assign miss_sum = (!is_hit && r_miss_tally != '1) ? r_miss_tally + 1'b1 : r_miss_tally;
    assign bit_val  = miss_sum < hit_sum;

    // Payload counters for the bit being decided
    assign pbits_inc = r_payload_bits + 1'b1;
    always_comb begin
        if (bit_val) begin
            zrun_upd = '0;
        end else if (r_zero_run < vbspd_pkg::ZERO_BYTE_LEN) begin
            zrun_upd = r_zero_run + 1'b1;
        end else begin
            zrun_upd = r_zero_run;
        end
    end
    assign zero_byte_end = (zrun_upd >= vbspd_pkg::ZERO_BYTE_LEN) && (pbits_inc[2:0] == 3'd0);

    // Decide the bit and run the hunt / payload framing
    always_comb begin
        n_hit_tally    = hit_sum;
        n_miss_tally   = miss_sum;
        n_previous_bit = r_previous_bit;
        n_flips_left   = r_flips_left;
        n_in_payload   = r_in_payload;
        n_payload_bits = r_payload_bits;
        n_zero_run     = r_zero_run;
        n_out_bit      = bit_val;
        n_out_end      = 1'b0;
        n_out_flags    = '0;

        if (i_s_tlast) begin
            n_hit_tally  = '0;
            n_miss_tally = '0;
            if (!r_in_payload) begin
                if (r_flips_left == '0 && bit_val && r_previous_bit) begin
                    n_out_flags.sync_found = 1'b1;
                    n_in_payload   = 1'b1;
                    n_payload_bits = '0;
                    n_zero_run     = '0;
                end else if (r_flips_left != '0 && bit_val != r_previous_bit) begin
                    n_flips_left = r_flips_left - 1'b1;
                end else if (bit_val == r_previous_bit) begin
                    n_flips_left = r_flips_needed;
                end
                n_previous_bit = bit_val;
            end else begin
                n_out_flags.payload_valid = 1'b1;
                n_payload_bits = pbits_inc;
                n_zero_run     = zrun_upd;
                if (zero_byte_end) begin
                    n_out_end = 1'b1;
                end else if (pbits_inc >= vbspd_pkg::MAX_PBITS) begin
                    n_out_end = 1'b1;
                    n_out_flags.length_overflow = 1'b1;
                end
                // Drop back to hunting after the last payload bit
                if (n_out_end) begin
                    n_in_payload   = 1'b0;
                    n_previous_bit = 1'b1;
                    n_flips_left   = r_flips_needed;
                    n_payload_bits = '0;
                    n_zero_run     = '0;
                end
            end
        end
    end

    // Update state on each accepted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_tally    <= '0;
            r_miss_tally   <= '0;
            r_previous_bit <= 1'b1;
            r_flips_left   <= vbspd_pkg::FLIPS_NEEDED_RST;
            r_in_payload   <= 1'b0;
            r_payload_bits <= '0;
            r_zero_run     <= '0;
        end else if (s_accept) begin
            r_hit_tally    <= n_hit_tally;
            r_miss_tally   <= n_miss_tally;
            r_previous_bit <= n_previous_bit;
            r_flips_left   <= n_flips_left;
            r_in_payload   <= n_in_payload;
            r_payload_bits <= n_payload_bits;
            r_zero_run     <= n_zero_run;
        end
    end

    // Output request valid: load on a closing sample, clear when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= i_s_tlast;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output request payload
    always_ff @(posedge i_clk) begin
        if (s_accept && i_s_tlast) begin
            r_out_bit   <= n_out_bit;
            r_out_end   <= n_out_end;
            r_out_flags <= n_out_flags;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(vbspd_pkg::M_TDATA_W-1){1'b0}}, r_out_bit};
    assign o_m_tlast  = r_out_end;
    assign o_m_tuser  = r_out_flags;

endmodule

// File: hdl/vbspd_checker.sv
// Port-level checks for the bit slicer and deframer, bound to its top level.
module vbspd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_s_tready,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [vbspd_pkg::M_TDATA_W-1:0]     o_m_tdata,
    input logic                                o_m_tlast,
    input logic [vbspd_pkg::M_TUSER_W-1:0]     o_m_tuser
);

    // Input stalls only behind a held, untaken result
    a_ready_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without a blocked result");

    // Message end only on payload bits
    a_end_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> o_m_tuser[0])
        else $error("message end on a non-payload bit");

    // Sync interval is a hunt bit of value one
    a_sync_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata[0] && !o_m_tuser[0] && !o_m_tlast))
        else $error("malformed sync result");

    // Length overflow always ends the message
    a_ovf_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2]) |-> o_m_tlast)
        else $error("length overflow without message end");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind vote_bit_slicer_preamble_deframer_top vbspd_checker u_vbspd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
